// File: src/rfbs_pkg.sv
// Shared types, constants and header byte function of the rotated framebuffer burst streamer.
`timescale 1ns / 1ps
`default_nettype none
package rfbs_pkg;

    localparam int COORD_W  = 13;
    localparam int COLOUR_W = 24;
    localparam int SYNC_LEN = 32;
    localparam int HDR_LEN  = 40;
    localparam int POS_W    = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_FILL = 2'd1;
    localparam logic [1:0] CMD_EMIT = 2'd2;

    localparam logic [1:0] ROT_PLUS  = 2'd1;
    localparam logic [1:0] ROT_MINUS = 2'd2;

    localparam logic REG_ROTATION   = 1'b0;
    localparam logic REG_BRIGHTNESS = 1'b1;

    localparam logic [1:0] ROT_RESET    = 2'd0;
    localparam logic [7:0] BRIGHT_RESET = 8'd127;

    localparam logic [7:0] MODE_TAG = 8'hfb;
    localparam logic [7:0] MODE_CFG = 8'h09;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [15:0] SYNC_WORDS [16] = '{
        16'hac92, 16'h3bca, 16'h41bf, 16'h393d, 16'ha74a, 16'hae01, 16'h155d, 16'hfb70,
        16'hf681, 16'h2f6d, 16'h4931, 16'h0fa3, 16'h77bf, 16'hd756, 16'h26f9, 16'h4eb6
    };

    typedef enum logic [1:0] {
        K_SET  = 2'd0,
        K_FILL = 2'd1,
        K_EMIT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [COLOUR_W-1:0]   colour;
    } t_op_ctl;

    // Sync words go out low byte first, then the eight mode bytes.
    function automatic logic [7:0] header_byte(input logic [POS_W-1:0] pos,
                                               input logic [7:0] bright,
                                               input logic [15:0] width);
        logic [15:0] w;
        logic [7:0]  b;
        w = SYNC_WORDS[pos[4:1]];
        if (pos < POS_W'(SYNC_LEN)) begin
            b = pos[0] ? w[15:8] : w[7:0];
        end else begin
            case (pos[2:0])
                3'd0: b = MODE_TAG;
                3'd2: b = MODE_CFG;
                3'd3: b = bright;
                3'd4: b = width[7:0];
                3'd5: b = width[15:8];
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// File: src/rfbs_front.sv
// Front end: accepts items, drops off-panel pixels, rotates and computes store addresses.
`timescale 1ns / 1ps
`default_nettype none
module rfbs_front #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 64,
    parameter int AW           = 12
) (
    input  wire logic                             i_in_valid,
    input  wire logic [1:0]                       i_command,
    input  wire logic signed [rfbs_pkg::COORD_W-1:0] i_pixel_x,
    input  wire logic signed [rfbs_pkg::COORD_W-1:0] i_pixel_y,
    input  wire logic [rfbs_pkg::COLOUR_W-1:0]    i_colour,
    input  wire logic [1:0]                       i_rotation,
    input  wire logic                             i_q_full,
    input  wire logic                             i_clearing,
    output logic                                  o_in_stall,
    output logic                                  o_push,
    output rfbs_pkg::t_op_ctl                     o_op,
    output logic [AW-1:0]                         o_addr
);
    localparam int MAXD = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int CW   = $clog2(MAXD + 1);
    localparam int PW   = AW + 1;
    localparam int LW   = rfbs_pkg::COORD_W - 1;

    logic          accept;
    logic          x_ok, y_ok, x_in_h, y_in_w, rotating, set_ok;
    logic [CW-1:0] xs, ys, nx, ny;
    logic [PW-1:0] addr_full;

    assign o_in_stall = i_q_full | i_clearing;
    assign accept     = i_in_valid & ~o_in_stall;

    assign x_ok   = ~i_pixel_x[LW] && (i_pixel_x[LW-1:0] < LW'(PANEL_WIDTH));
    assign y_ok   = ~i_pixel_y[LW] && (i_pixel_y[LW-1:0] < LW'(PANEL_HEIGHT));
    assign x_in_h = i_pixel_x[LW-1:0] < LW'(PANEL_HEIGHT);
    assign y_in_w = i_pixel_y[LW-1:0] < LW'(PANEL_WIDTH);
    assign rotating = (i_rotation == rfbs_pkg::ROT_PLUS) || (i_rotation == rfbs_pkg::ROT_MINUS);

    // Both quarter turns keep a point on the panel only inside the common square.
    assign set_ok = x_ok && y_ok && (!rotating || (x_in_h && y_in_w));

    assign xs = i_pixel_x[CW-1:0];
    assign ys = i_pixel_y[CW-1:0];

    always_comb begin
        case (i_rotation)
            rfbs_pkg::ROT_PLUS: begin
                nx = ys;
                ny = CW'(PANEL_HEIGHT - 1) - xs;
            end
            rfbs_pkg::ROT_MINUS: begin
                nx = CW'(PANEL_WIDTH - 1) - ys;
                ny = xs;
            end
            default: begin
                nx = xs;
                ny = ys;
            end
        endcase
    end

    assign addr_full = PW'(nx) + PW'(PANEL_WIDTH) * PW'(ny);
    assign o_addr    = addr_full[AW-1:0];

    always_comb begin
        o_op.colour = i_colour;
        o_op.kind   = rfbs_pkg::K_SET;
        o_push      = 1'b0;
        case (i_command)
            rfbs_pkg::CMD_SET: begin
                o_push = accept & set_ok;
            end
            rfbs_pkg::CMD_FILL: begin
                o_op.kind = rfbs_pkg::K_FILL;
                o_push    = accept;
            end
            rfbs_pkg::CMD_EMIT: begin
                o_op.kind = rfbs_pkg::K_EMIT;
                o_push    = accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: src/rfbs_queue.sv
// Short first-in first-out queue of decoded operations between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module rfbs_queue #(
    parameter int DATA_W = 38
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_push_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);
    localparam int DEPTH = rfbs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slots [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slots[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("operation pushed into a full queue");
endmodule
`default_nettype wire

// File: src/rfbs_back.sv
// Back end: frame store, fill and clearing sweeps, burst sequencing and output register.
`timescale 1ns / 1ps
`default_nettype none
module rfbs_back #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 64,
    parameter int AW           = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire rfbs_pkg::t_op_ctl     i_op,
    input  wire logic [AW-1:0]         i_addr,
    input  wire logic [7:0]            i_brightness,
    output logic                       o_pop,
    output logic                       o_clearing,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_tx_byte,
    output logic                       o_last_of_burst
);
    localparam int NPIX  = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int POS_W = rfbs_pkg::POS_W;
    localparam int CW    = rfbs_pkg::COLOUR_W;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_FILL  = 4'b0100,
        ST_READ  = 4'b1000
    } t_state;

    logic [CW-1:0] r_mem [NPIX];
    logic [CW-1:0] r_rd_data;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_sweep, n_sweep;
    logic [POS_W-1:0] r_hdr_pos, n_hdr_pos;
    logic             r_in_frame, n_in_frame;
    logic [AW-1:0]    r_pix, n_pix;
    logic [1:0]       r_ch, n_ch;
    logic             r_out_valid, n_out_valid;

    logic [CW-1:0]    r_fill_colour, n_fill_colour;
    logic [7:0]       r_hdr_byte, n_hdr_byte;
    logic             r_sel_frame, n_sel_frame;
    logic [1:0]       r_sel_ch, n_sel_ch;
    logic             r_sel_last, n_sel_last;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;

    logic             mem_we, rd_en, out_take, out_free, sweep_end;
    logic [AW-1:0]    mem_waddr;
    logic [CW-1:0]    mem_wdata;
    logic [7:0]       frame_byte;

    assign out_take  = r_out_valid & ~i_out_stall;
    assign out_free  = ~r_out_valid | ~i_out_stall;
    assign sweep_end = (r_sweep == AW'(NPIX - 1));

    always_comb begin
        case (r_sel_ch)
            rfbs_pkg::CH_RED:   frame_byte = r_rd_data[23:16];
            rfbs_pkg::CH_GREEN: frame_byte = r_rd_data[15:8];
            default:            frame_byte = r_rd_data[7:0];
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_sweep       = r_sweep;
        n_hdr_pos     = r_hdr_pos;
        n_in_frame    = r_in_frame;
        n_pix         = r_pix;
        n_ch          = r_ch;
        n_fill_colour = r_fill_colour;
        n_hdr_byte    = r_hdr_byte;
        n_sel_frame   = r_sel_frame;
        n_sel_ch      = r_sel_ch;
        n_sel_last    = r_sel_last;
        n_out_valid   = r_out_valid & ~out_take;
        n_out_byte    = r_out_byte;
        n_out_last    = r_out_last;
        o_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = i_addr;
        mem_wdata     = i_op.colour;
        rd_en         = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                mem_wdata = '0;
                n_sweep   = sweep_end ? '0 : r_sweep + 1'b1;
                if (sweep_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                mem_wdata = r_fill_colour;
                n_sweep   = sweep_end ? '0 : r_sweep + 1'b1;
                if (sweep_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_op.kind)
                        rfbs_pkg::K_SET: begin
                            o_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        rfbs_pkg::K_FILL: begin
                            o_pop         = 1'b1;
                            n_fill_colour = i_op.colour;
                            n_sweep       = '0;
                            n_state       = ST_FILL;
                        end
                        rfbs_pkg::K_EMIT: begin
                            // The output slot must be free by the cycle the byte is loaded.
                            if (out_free) begin
                                o_pop       = 1'b1;
                                n_state     = ST_READ;
                                n_sel_frame = r_in_frame;
                                n_sel_ch    = r_ch;
                                n_sel_last  = r_in_frame && (r_ch == rfbs_pkg::CH_BLUE)
                                              && (r_pix == AW'(NPIX - 1));
                                if (!r_in_frame) begin
                                    n_hdr_byte = rfbs_pkg::header_byte(r_hdr_pos, i_brightness,
                                                                       16'(PANEL_WIDTH));
                                    if (r_hdr_pos == POS_W'(rfbs_pkg::HDR_LEN - 1)) begin
                                        n_in_frame = 1'b1;
                                        n_pix      = '0;
                                        n_ch       = rfbs_pkg::CH_RED;
                                    end else begin
                                        n_hdr_pos = r_hdr_pos + 1'b1;
                                    end
                                end else begin
                                    rd_en = 1'b1;
                                    if (r_ch == rfbs_pkg::CH_BLUE) begin
                                        n_ch = rfbs_pkg::CH_RED;
                                        if (r_pix == AW'(NPIX - 1)) begin
                                            n_in_frame = 1'b0;
                                            n_hdr_pos  = '0;
                                        end else begin
                                            n_pix = r_pix + 1'b1;
                                        end
                                    end else begin
                                        n_ch = r_ch + 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_out_byte  = r_sel_frame ? frame_byte : r_hdr_byte;
                n_out_last  = r_sel_last;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_sweep     <= '0;
            r_hdr_pos   <= '0;
            r_in_frame  <= 1'b0;
            r_pix       <= '0;
            r_ch        <= rfbs_pkg::CH_RED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_hdr_pos   <= n_hdr_pos;
            r_in_frame  <= n_in_frame;
            r_pix       <= n_pix;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_colour <= n_fill_colour;
        r_hdr_byte    <= n_hdr_byte;
        r_sel_frame   <= n_sel_frame;
        r_sel_ch      <= n_sel_ch;
        r_sel_last    <= n_sel_last;
        r_out_byte    <= n_out_byte;
        r_out_last    <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_pix];
        end
    end

    assign o_clearing      = (r_state == ST_CLEAR);
    assign o_out_valid     = r_out_valid;
    assign o_tx_byte       = r_out_byte;
    assign o_last_of_burst = r_out_last;

    a_read_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> r_out_valid)
        else $error("burst byte not loaded after its read cycle");

    a_header_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_hdr_pos < POS_W'(rfbs_pkg::HDR_LEN)))
        else $error("header position past the mode bytes");

    a_no_pop_while_sweeping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL || r_state == ST_CLEAR) |-> !o_pop)
        else $error("operation taken during a store sweep");

    a_last_only_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && r_sel_last) |-> r_sel_frame)
        else $error("last flag on a header byte");
endmodule
`default_nettype wire

// File: src/rotated_framebuffer_burst_streamer.sv
// Top level of the rotated framebuffer burst streamer: configuration registers and wiring.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_command, i_pixel_x, i_pixel_y, i_colour
//   output    out        o_out_valid / i_out_stall  o_tx_byte, o_last_of_burst
//   config    in/out     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// A set-pixel transaction is written to the store as it is taken from the queue; a next-byte
// transaction passes through the idle state, which issues the frame store read or forms the
// header byte, and then the read state, which loads the output register. A fill is taken
// from the queue, then writes the store one pixel per cycle. After reset a clearing pass
// zeroes the store; no input transaction is accepted during it. A four-entry queue lets the
// front keep accepting while the back end sweeps or waits on a stalled output.
`timescale 1ns / 1ps
`default_nettype none
module rotated_framebuffer_burst_streamer #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_command,
    input  wire logic signed [rfbs_pkg::COORD_W-1:0] i_pixel_x,
    input  wire logic signed [rfbs_pkg::COORD_W-1:0] i_pixel_y,
    input  wire logic [rfbs_pkg::COLOUR_W-1:0]       i_colour,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [7:0]                               o_tx_byte,
    output logic                                     o_last_of_burst,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    localparam int NPIX   = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int AW     = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int DATA_W = $bits(rfbs_pkg::t_op_ctl) + AW;

    logic [1:0] r_rotation;
    logic [7:0] r_brightness;
    logic       cfg_write;

    logic               push, pop, q_full, q_valid, clearing;
    rfbs_pkg::t_op_ctl  push_op, pop_op;
    logic [AW-1:0]      push_addr, pop_addr;
    logic [DATA_W-1:0]  q_out;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation   <= rfbs_pkg::ROT_RESET;
            r_brightness <= rfbs_pkg::BRIGHT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                rfbs_pkg::REG_ROTATION:   r_rotation   <= pwdata[1:0];
                rfbs_pkg::REG_BRIGHTNESS: r_brightness <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rfbs_pkg::REG_ROTATION:   prdata = {30'd0, r_rotation};
            rfbs_pkg::REG_BRIGHTNESS: prdata = {24'd0, r_brightness};
            default:                  prdata = '0;
        endcase
    end

    rfbs_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .AW           (AW)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_colour   (i_colour),
        .i_rotation (r_rotation),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_op       (push_op),
        .o_addr     (push_addr)
    );

    rfbs_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_op, push_addr}),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_out)
    );

    assign pop_op   = q_out[DATA_W-1:AW];
    assign pop_addr = q_out[AW-1:0];

    rfbs_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .AW           (AW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_op            (pop_op),
        .i_addr          (pop_addr),
        .i_brightness    (r_brightness),
        .o_pop           (pop),
        .o_clearing      (clearing),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_tx_byte       (o_tx_byte),
        .o_last_of_burst (o_last_of_burst)
    );
endmodule
`default_nettype wire

// File: test/tb_rotated_framebuffer_burst_streamer.sv
// Self-checking testbench for the rotated framebuffer burst streamer.
`timescale 1ns / 1ps
module tb_rotated_framebuffer_burst_streamer;

    localparam int PANEL_W      = 64;
    localparam int PANEL_H      = 64;
    localparam int PIXELS       = PANEL_W * PANEL_H;
    localparam int SYNC_BYTES   = 32;
    localparam int HEADER_BYTES = 40;
    localparam int BURST_LEN    = HEADER_BYTES + 3 * PIXELS;

    // Up to five fills can sit in the queue and the back end, one pixel per cycle each.
    localparam int SETTLE_CYCLES = 5 * PIXELS + 64;
    localparam int QUIET_LIMIT   = 16 * PIXELS;

    localparam int RANDOM_PHASES      = 5;
    localparam int RANDOM_PHASE_ITEMS = 300;
    localparam int FINAL_ITEMS        = 150;

    localparam logic [1:0] CMD_NONE  = 2'd3;
    localparam logic [1:0] ROT_NONE  = 2'd0;
    localparam logic [1:0] ROT_SPARE = 2'd3;

    localparam logic [2:0] ADDR_ROTATION   = 3'd0;
    localparam logic [2:0] ADDR_BRIGHTNESS = 3'd4;

    localparam logic [15:0] SYNC_PATTERN [16] = '{
        16'hac92, 16'h3bca, 16'h41bf, 16'h393d, 16'ha74a, 16'hae01, 16'h155d, 16'hfb70,
        16'hf681, 16'h2f6d, 16'h4931, 16'h0fa3, 16'h77bf, 16'hd756, 16'h26f9, 16'h4eb6
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_burst_byte;

    typedef struct packed {
        logic [1:0]                          cmd;
        logic signed [rfbs_pkg::COORD_W-1:0] x;
        logic signed [rfbs_pkg::COORD_W-1:0] y;
        logic [rfbs_pkg::COLOUR_W-1:0]       colour;
        logic                                pinned;
        logic [7:0]                          exp_data;
        logic                                exp_last;
    } t_stim_row;

    // Rows with pinned set carry the sync bytes that follow straight from reset.
    localparam t_stim_row DIRECTED [20] = '{
        '{rfbs_pkg::CMD_EMIT, 13'h0555, 13'h0aaa, 24'h5a5a5a, 1'b1, 8'h92, 1'b0},
        '{rfbs_pkg::CMD_EMIT, 13'h1aaa, 13'h1555, 24'ha5a5a5, 1'b1, 8'hac, 1'b0},
        '{rfbs_pkg::CMD_FILL, 13'h0fff, 13'h1000, 24'h0000ff, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'd0,    13'd0,    24'hffffff, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'd63,   13'd63,   24'hff0000, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'd63,   13'd0,    24'h00ff00, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'd0,    13'd63,   24'h000000, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'h1fff, 13'd0,    24'h123456, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'd0,    13'h1fff, 24'h654321, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'd64,   13'd10,   24'habcdef, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'd10,   13'd64,   24'hfedcba, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'h1000, 13'h1000, 24'hffffff, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'h0fff, 13'h0fff, 24'hffffff, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'h1000, 13'h0fff, 24'hffffff, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'h0fff, 13'h1000, 24'hffffff, 1'b0, 8'h00, 1'b0},
        '{CMD_NONE,           13'd5,    13'd5,    24'hffffff, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_EMIT, 13'd0,    13'd0,    24'h000000, 1'b1, 8'hca, 1'b0},
        '{rfbs_pkg::CMD_EMIT, 13'h1fff, 13'h1fff, 24'hffffff, 1'b1, 8'h3b, 1'b0},
        '{rfbs_pkg::CMD_SET,  13'd1,    13'd2,    24'h800001, 1'b0, 8'h00, 1'b0},
        '{rfbs_pkg::CMD_EMIT, 13'd3,    13'd4,    24'h0f0f0f, 1'b0, 8'h00, 1'b0}
    };

    logic                                i_clk;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic [1:0]                          i_command   = rfbs_pkg::CMD_SET;
    logic signed [rfbs_pkg::COORD_W-1:0] i_pixel_x   = '0;
    logic signed [rfbs_pkg::COORD_W-1:0] i_pixel_y   = '0;
    logic [rfbs_pkg::COLOUR_W-1:0]       i_colour    = '0;
    logic                                i_out_stall = 1'b0;
    logic                                psel        = 1'b0;
    logic                                penable     = 1'b0;
    logic                                pwrite      = 1'b0;
    logic [2:0]                          paddr       = '0;
    logic [31:0]                         pwdata      = '0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic [7:0]                          o_tx_byte;
    logic                                o_last_of_burst;
    logic [31:0]                         prdata;
    logic                                pready;

    rotated_framebuffer_burst_streamer #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_colour       (i_colour),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tx_byte      (o_tx_byte),
        .o_last_of_burst(o_last_of_burst),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Shadow copy of the block state.
    logic [rfbs_pkg::COLOUR_W-1:0] shadow_frame [PIXELS];
    int                            burst_pos;
    logic [1:0]                    shadow_rotation;
    logic [7:0]                    shadow_brightness;

    t_burst_byte pending_bytes [$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    bit          settling     = 1'b0;
    bit          idling_on    = 1'b1;
    int          stall_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [7:0] header_byte_at(input int pos);
        logic [15:0] w;
        w = SYNC_PATTERN[(pos >> 1) & 15];
        if (pos < SYNC_BYTES) begin
            return pos[0] ? w[15:8] : w[7:0];
        end
        case (pos - SYNC_BYTES)
            0: return 8'hfb;
            1: return 8'h00;
            2: return 8'h09;
            3: return shadow_brightness;
            4: return 8'(PANEL_W);
            5: return 8'(PANEL_W >> 8);
            default: return 8'h00;
        endcase
    endfunction

    task automatic model_item(input logic [1:0] cmd,
                              input logic signed [rfbs_pkg::COORD_W-1:0] x,
                              input logic signed [rfbs_pkg::COORD_W-1:0] y,
                              input logic [rfbs_pkg::COLOUR_W-1:0] colour,
                              output bit has_out, output t_burst_byte out);
        int xi, yi, nx, ny, pos, off;
        logic [rfbs_pkg::COLOUR_W-1:0] pix;
        has_out = 1'b0;
        out     = '0;
        xi      = x;
        yi      = y;
        case (cmd)
            rfbs_pkg::CMD_SET: begin
                if (xi >= 0 && yi >= 0 && xi < PANEL_W && yi < PANEL_H) begin
                    if (shadow_rotation == rfbs_pkg::ROT_PLUS) begin
                        nx = yi;
                        ny = PANEL_H - 1 - xi;
                    end else if (shadow_rotation == rfbs_pkg::ROT_MINUS) begin
                        nx = PANEL_W - 1 - yi;
                        ny = xi;
                    end else begin
                        nx = xi;
                        ny = yi;
                    end
                    // On a non-square panel the turned point can fall off the edge.
                    if (nx >= 0 && ny >= 0 && nx < PANEL_W && ny < PANEL_H)
                        shadow_frame[nx + PANEL_W * ny] = colour;
                end
            end
            rfbs_pkg::CMD_FILL: begin
                foreach (shadow_frame[i]) shadow_frame[i] = colour;
            end
            rfbs_pkg::CMD_EMIT: begin
                pos = burst_pos;
                if (pos >= BURST_LEN) pos = 0;
                if (pos < HEADER_BYTES) begin
                    out.data = header_byte_at(pos);
                end else begin
                    off      = pos - HEADER_BYTES;
                    pix      = shadow_frame[(off / 3) % PIXELS];
                    out.data = 8'(pix >> (16 - 8 * (off % 3)));
                end
                out.last  = (pos == BURST_LEN - 1);
                burst_pos = (pos + 1 >= BURST_LEN) ? 0 : pos + 1;
                has_out   = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
    endtask

    task automatic send_item(input logic [1:0] cmd,
                             input logic signed [rfbs_pkg::COORD_W-1:0] x,
                             input logic signed [rfbs_pkg::COORD_W-1:0] y,
                             input logic [rfbs_pkg::COLOUR_W-1:0] colour,
                             input bit pinned, input t_burst_byte pinned_out);
        bit          has_out;
        t_burst_byte predicted;
        int          gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        i_colour   <= colour;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model_item(cmd, x, y, colour, has_out, predicted);
        if (has_out) pending_bytes.push_back(pinned ? pinned_out : predicted);
    endtask

    task automatic random_item(output logic [1:0] cmd,
                               output logic signed [rfbs_pkg::COORD_W-1:0] x,
                               output logic signed [rfbs_pkg::COORD_W-1:0] y,
                               output logic [rfbs_pkg::COLOUR_W-1:0] colour);
        int pick;
        pick = $urandom_range(0, 199);
        x    = 13'($urandom);
        y    = 13'($urandom);
        case ($urandom_range(0, 7))
            0: colour = 24'hffffff;
            1: colour = 24'h000000;
            2: colour = 24'hff0000;
            3: colour = 24'h00ff00;
            4: colour = 24'h0000ff;
            default: colour = 24'($urandom);
        endcase
        if (pick < 110) begin
            cmd = rfbs_pkg::CMD_SET;
            x   = 13'($urandom_range(0, PANEL_W - 1));
            y   = 13'($urandom_range(0, PANEL_H - 1));
            if ($urandom_range(0, 7) == 0) x = $urandom_range(0, 1) ? 13'(PANEL_W - 1) : '0;
            if ($urandom_range(0, 7) == 0) y = $urandom_range(0, 1) ? 13'(PANEL_H - 1) : '0;
        end else if (pick < 126) begin
            // Points just past an edge, or anywhere in the coordinate range.
            cmd = rfbs_pkg::CMD_SET;
            case ($urandom_range(0, 4))
                0: x = -13'sd1;
                1: x = 13'(PANEL_W);
                2: y = -13'sd1;
                3: y = 13'(PANEL_H);
                default: ;
            endcase
        end else if (pick < 196) begin
            cmd = rfbs_pkg::CMD_EMIT;
        end else if (pick < 198) begin
            cmd = rfbs_pkg::CMD_FILL;
            if ($urandom_range(0, 2) == 0) colour = '0;
        end else begin
            cmd = CMD_NONE;
        end
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ROTATION) shadow_rotation = value[1:0];
        else if (addr == ADDR_BRIGHTNESS) shadow_brightness = value[7:0];
    endtask

    // Sender holds off until every byte is back and any trailing fill has finished.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        settling = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        settling = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!idling_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 7);
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= $urandom_range(0, 15);
        end
    end

    always @(posedge i_clk) begin
        t_burst_byte want;
        if (o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                note_mismatch("unexpected transaction", '0,
                              32'({o_last_of_burst, o_tx_byte}));
            end else begin
                want = pending_bytes.pop_front();
                if (o_tx_byte !== want.data)
                    note_mismatch("tx_byte", 32'(want.data), 32'(o_tx_byte));
                if (o_last_of_burst !== want.last)
                    note_mismatch("last_of_burst", 32'(want.last), 32'(o_last_of_burst));
            end
        end
        if (settling || (o_out_valid === 1'b1 && !i_out_stall)
                || (i_in_valid && o_in_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [1:0]                          cmd;
        logic signed [rfbs_pkg::COORD_W-1:0] x, y;
        logic [rfbs_pkg::COLOUR_W-1:0]       colour;
        t_burst_byte                         pinned;
        logic [1:0]                          rot_plan [RANDOM_PHASES];
        logic [7:0]                          bright_plan [RANDOM_PHASES];
        rot_plan    = '{rfbs_pkg::ROT_PLUS, rfbs_pkg::ROT_MINUS, ROT_SPARE, ROT_NONE,
                        rfbs_pkg::ROT_MINUS};
        bright_plan = '{8'd0, 8'd255, 8'($urandom), 8'd1, 8'($urandom)};
        foreach (shadow_frame[i]) shadow_frame[i] = '0;
        burst_pos         = 0;
        shadow_rotation   = rfbs_pkg::ROT_RESET;
        shadow_brightness = rfbs_pkg::BRIGHT_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            pinned.data = DIRECTED[i].exp_data;
            pinned.last = DIRECTED[i].exp_last;
            send_item(DIRECTED[i].cmd, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].colour,
                      DIRECTED[i].pinned, pinned);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            write_reg(ADDR_ROTATION, {30'd0, rot_plan[p]});
            write_reg(ADDR_BRIGHTNESS, {24'd0, bright_plan[p]});
            repeat (RANDOM_PHASE_ITEMS) begin
                random_item(cmd, x, y, colour);
                send_item(cmd, x, y, colour, 1'b0, '0);
            end
        end

        wait_drained();
        idling_on = 1'b0;
        write_reg(ADDR_ROTATION, {30'd0, rfbs_pkg::ROT_PLUS});
        write_reg(ADDR_BRIGHTNESS, {24'd0, rfbs_pkg::BRIGHT_RESET});
        repeat (FINAL_ITEMS) begin
            random_item(cmd, x, y, colour);
            send_item(cmd, x, y, colour, 1'b0, '0);
        end

        wait_drained();
        mismatches += pending_bytes.size();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
src/rfbs_pkg.sv
src/rfbs_front.sv
src/rfbs_queue.sv
src/rfbs_back.sv
src/rotated_framebuffer_burst_streamer.sv
test/tb_rotated_framebuffer_burst_streamer.sv
